>>> src/ksu_pkg.sv
// Shared constants and types for the Kronecker symbol unit.
package ksu_pkg;

  localparam int WIDTH = 64;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_ONE  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_STRIPB,
    ST_LOOP,
    ST_STRIPA,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> src/ksu_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ksu_rem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ksu_pkg::WIDTH-1:0]  dividend,
  input  logic [ksu_pkg::WIDTH-1:0]  divisor,
  output logic                       done,
  output logic [ksu_pkg::WIDTH-1:0]  rem
);

  logic                        busy;
  logic [ksu_pkg::CNT_W-1:0]   cnt;
  logic [ksu_pkg::WIDTH-1:0]   sh;
  logic [ksu_pkg::WIDTH-1:0]   d;
  logic [ksu_pkg::WIDTH:0]     trial;
  logic [ksu_pkg::WIDTH:0]     diff;

  assign trial = {rem, sh[ksu_pkg::WIDTH-1]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ksu_pkg::CNT_W'(ksu_pkg::WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sh  <= dividend;
      d   <= divisor;
    end else if (busy) begin
      sh <= {sh[ksu_pkg::WIDTH-2:0], 1'b0};
      if (!diff[ksu_pkg::WIDTH]) begin
        rem <= diff[ksu_pkg::WIDTH-1:0];
      end else begin
        rem <= trial[ksu_pkg::WIDTH-1:0];
      end
    end
  end

endmodule

>>> src/kronecker_symbol_unit_core.sv
// Kronecker symbol unit top level: sequencer, operand registers, remainder unit, output register.
// Usage:
//   Input channel: in_valid/in_stall with operand_a, operand_b (signed WIDTH bits).
//   Output channel: out_valid/out_stall with symbol_value (-1 as 2'b11, 0, 1).
//   One item is worked at a time; in_stall is high from acceptance until the
//   result has been placed in the output register.
//   Zero b or both-even operands go straight to the result; otherwise b is
//   stripped of factors of two, then each Euclid step strips a and runs the
//   bit-serial remainder unit, which dominates the time of a step.
//   The output register holds a result until taken; a new item may be accepted
//   while it waits, and its result waits in the sequencer until the register
//   frees.
//   Reset (rst, synchronous) empties the output register and returns to idle.
module kronecker_symbol_unit_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ksu_pkg::WIDTH-1:0]  operand_a,
  input  logic signed [ksu_pkg::WIDTH-1:0]  operand_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [1:0]                 symbol_value
);

  ksu_pkg::state_t            state, state_next;
  logic [ksu_pkg::WIDTH-1:0]  am, bm, rem;
  logic                       aneg, ks, par;
  logic [1:0]                 res;
  logic                       div_start;
  logic                       div_done;
  logic                       out_free;
  logic                       flip;
  logic                       ldres;

  assign in_stall  = (state != ksu_pkg::ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  ksu_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bm),
    .divisor  (am),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ldres      = 1'b0;
    flip       = (par && (bm[2:0] == 3'd3 || bm[2:0] == 3'd5))
               ^ ((aneg ? ~am[1] : am[1]) & bm[1]);
    case (state)
      ksu_pkg::ST_IDLE:   if (in_valid) state_next = ksu_pkg::ST_CHK;
      ksu_pkg::ST_CHK: begin
        if (bm == '0 || (!am[0] && !bm[0])) state_next = ksu_pkg::ST_DONE;
        else state_next = ksu_pkg::ST_STRIPB;
      end
      ksu_pkg::ST_STRIPB: if (bm[0]) state_next = ksu_pkg::ST_LOOP;
      ksu_pkg::ST_LOOP: begin
        if (am == '0) state_next = ksu_pkg::ST_DONE;
        else state_next = ksu_pkg::ST_STRIPA;
      end
      ksu_pkg::ST_STRIPA: begin
        if (am[0]) begin
          div_start  = 1'b1;
          state_next = ksu_pkg::ST_DIV;
        end
      end
      ksu_pkg::ST_DIV:    if (div_done) state_next = ksu_pkg::ST_LOOP;
      ksu_pkg::ST_DONE: begin
        if (out_free) begin
          ldres      = 1'b1;
          state_next = ksu_pkg::ST_IDLE;
        end
      end
      default:            state_next = ksu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ksu_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ksu_pkg::ST_IDLE: begin
        aneg <= operand_a[ksu_pkg::WIDTH-1];
        am   <= operand_a[ksu_pkg::WIDTH-1] ? ('0 - operand_a) : operand_a;
        ks   <= operand_a[ksu_pkg::WIDTH-1] & operand_b[ksu_pkg::WIDTH-1];
        bm   <= operand_b[ksu_pkg::WIDTH-1] ? ('0 - operand_b) : operand_b;
        par  <= 1'b0;
      end
      ksu_pkg::ST_CHK: begin
        if (bm == '0) res <= (am == ksu_pkg::WIDTH'(1)) ? ksu_pkg::SYM_ONE : ksu_pkg::SYM_ZERO;
        else          res <= ksu_pkg::SYM_ZERO;
      end
      ksu_pkg::ST_STRIPB: begin
        if (!bm[0]) begin
          bm  <= bm >> 1;
          par <= ~par;
        end else if (par && (am[2:0] == 3'd3 || am[2:0] == 3'd5)) begin
          ks <= ~ks;
        end
      end
      ksu_pkg::ST_LOOP: begin
        par <= 1'b0;
        if (bm == ksu_pkg::WIDTH'(1)) res <= ks ? ksu_pkg::SYM_NEG : ksu_pkg::SYM_ONE;
        else                          res <= ksu_pkg::SYM_ZERO;
      end
      ksu_pkg::ST_STRIPA: begin
        if (!am[0]) begin
          am  <= am >> 1;
          par <= ~par;
        end else begin
          ks   <= ks ^ flip;
          aneg <= 1'b0;
        end
      end
      ksu_pkg::ST_DIV: begin
        if (div_done) begin
          bm <= am;
          am <= rem;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ldres) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ldres) symbol_value <= res;
  end

  a_loop_b_odd: assert property (@(posedge clk) disable iff (rst)
    state == ksu_pkg::ST_LOOP |-> bm[0])
    else $error("b even in loop");

  a_stripa_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ksu_pkg::ST_STRIPA |-> am != '0)
    else $error("stripping zero a");

  a_code_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> symbol_value != 2'sb10)
    else $error("bad symbol code");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == ksu_pkg::ST_DIV)
    else $error("remainder start outside divide");

endmodule

>>> bench/kronecker_symbol_checker.sv
// Checker for the Kronecker symbol unit: predicts each symbol and compares on output.
`timescale 1ns / 100ps
module kronecker_symbol_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [ksu_pkg::WIDTH-1:0]  operand_a,
  input  logic signed [ksu_pkg::WIDTH-1:0]  operand_b,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [1:0]                 symbol_value,
  output int                                fail_count,
  output int                                pending_symbols
);

  logic [1:0] symbol_q[$];

  // (2/n) for odd n by n mod 8
  function automatic int two_char(logic [ksu_pkg::WIDTH-1:0] n);
    case (n[2:0])
      3'd1, 3'd7: two_char = 1;
      3'd3, 3'd5: two_char = -1;
      default:    two_char = 0;
    endcase
  endfunction

  function automatic logic [1:0] kronecker(logic [ksu_pkg::WIDTH-1:0] a_raw,
                                           logic [ksu_pkg::WIDTH-1:0] b_raw);
    logic [ksu_pkg::WIDTH-1:0] am, bm, r, abits;
    logic aneg, bneg;
    int k, v;
    aneg = a_raw[ksu_pkg::WIDTH-1];
    bneg = b_raw[ksu_pkg::WIDTH-1];
    am = aneg ? -a_raw : a_raw;
    bm = bneg ? -b_raw : b_raw;
    if (bm == 0) return (am == 1) ? ksu_pkg::SYM_ONE : ksu_pkg::SYM_ZERO;
    if (!am[0] && !bm[0]) return ksu_pkg::SYM_ZERO;
    v = 0;
    while (!bm[0]) begin
      bm = bm >> 1;
      v++;
    end
    k = v[0] ? two_char(am) : 1;
    if (aneg && bneg) k = -k;
    while (am != 0) begin
      v = 0;
      while (!am[0]) begin
        am = am >> 1;
        v++;
      end
      if (v[0]) k = k * two_char(bm);
      abits = aneg ? ~am : am;
      if (abits[1] & bm[1]) k = -k;
      r = am;
      am = bm % r;
      bm = r;
      aneg = 1'b0;
    end
    if (bm != 1) return ksu_pkg::SYM_ZERO;
    return (k < 0) ? ksu_pkg::SYM_NEG : ((k > 0) ? ksu_pkg::SYM_ONE : ksu_pkg::SYM_ZERO);
  endfunction

  assign pending_symbols = symbol_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst) begin
      if (in_valid && !in_stall) symbol_q.push_back(kronecker(operand_a, operand_b));
      if (out_valid && !out_stall) begin
        if (symbol_q.size() == 0) begin
          $display("%0t: unexpected symbol %0d", $time, symbol_value);
          fail_count <= fail_count + 1;
        end else begin
          want = symbol_q.pop_front();
          if (want !== symbol_value) begin
            $display("%0t: symbol mismatch expected %0d actual %0d", $time,
                     $signed(want), symbol_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/tb_kronecker_symbol_unit_core.sv
// Testbench top for the Kronecker symbol unit: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_kronecker_symbol_unit_core;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, out_stall = 1'b0;
  logic signed [ksu_pkg::WIDTH-1:0] operand_a = '0, operand_b = '0;
  logic in_stall, out_valid;
  logic signed [1:0] symbol_value;
  int fail_count, pending_symbols;
  int sent = 0;

  localparam logic [ksu_pkg::WIDTH-1:0] MIN_V = {1'b1, {(ksu_pkg::WIDTH-1){1'b0}}};
  localparam logic [ksu_pkg::WIDTH-1:0] MAX_V = {1'b0, {(ksu_pkg::WIDTH-1){1'b1}}};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kronecker_symbol_unit_core dut (.*);

  kronecker_symbol_checker chk (.*);

  // receiver pattern: stall phases of random length
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(negedge clk);
        out_stall <= (n == 0) ? 1'b0 : ($urandom_range(0, 3) < n);
      end
    end
  end

  function automatic logic [ksu_pkg::WIDTH-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ksu_pkg::WIDTH-1:0] rand_operand();
    logic [ksu_pkg::WIDTH-1:0] x;
    case ($urandom_range(0, 7))
      0: x = rand_word();
      1: x = rand_word() >> $urandom_range(1, ksu_pkg::WIDTH - 1);
      2: x = $urandom_range(0, 40);
      3: x = -$signed({32'd0, $urandom_range(0, 40)});
      4: x = rand_word() << $urandom_range(1, 20);
      5: x = ($urandom_range(0, 1)) ? MIN_V : MAX_V;
      6: x = {32'd0, $urandom} & ~64'd0;
      default: x = -$signed(rand_word() >> $urandom_range(1, ksu_pkg::WIDTH - 1));
    endcase
    return x;
  endfunction

  task automatic send(logic [ksu_pkg::WIDTH-1:0] a, logic [ksu_pkg::WIDTH-1:0] b);
    operand_a <= a;
    operand_b <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  initial begin
    logic [ksu_pkg::WIDTH-1:0] dir_a[$], dir_b[$];
    int burst;
    dir_a = '{0, 1, -1, 1, -1, 2, 0, 4, 3, MIN_V, MAX_V, MIN_V, MAX_V, 5, -5,
              7, 2, -3, 15, MAX_V, 12, 1001, -1001, MIN_V, 9};
    dir_b = '{0, 0, 0, 7, -7, 6, 8, 12, -8, MIN_V, MIN_V, MAX_V, MAX_V, 3, -3,
              16, 15, 5, 9, 3, -15, 9907, -9907, 1, 1};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_a[i]) send(dir_a[i], dir_b[i]);
    idle_gap();
    while (sent < 1425) begin
      burst = $urandom_range(1, 20);
      repeat (burst) send(rand_operand(), rand_operand());
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    in_valid <= 1'b0;
    while (pending_symbols != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d operand pairs: directed edge values plus random signed operands.",
             sent);
    $display("Symbols checked against the binary Euclid prediction; failures: %0d",
             fail_count);
    if (fail_count == 0 && pending_symbols == 0)
      $display("tb_kronecker_symbol_unit_core: PASS");
    else
      $display("tb_kronecker_symbol_unit_core: FAIL");
    $finish;
  end

  initial begin
    #1s;
    $display("tb_kronecker_symbol_unit_core: FAIL");
    $finish;
  end

endmodule
